### sv/rect_circle_raster_engine_assert.svh
// assertion macros shared by the raster engine modules
`ifndef RECT_CIRCLE_RASTER_ENGINE_ASSERT_SVH
`define RECT_CIRCLE_RASTER_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RCR_ASSERT(lbl, prop, msg)
`define RCR_NEVER(lbl, cond, msg)
`endif
`endif

### sv/rcr_pkg.sv
// types, constants and helpers of the raster engine
`default_nettype none
package rcr_pkg;

    localparam int SIDE   = 64;
    localparam int PIXELS = SIDE * SIDE;
    localparam int CW     = $clog2(SIDE);
    localparam int AW     = $clog2(PIXELS);
    localparam int CRD_W  = 10;
    localparam int QDEPTH = 2;
    localparam int QW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic signed [CRD_W-1:0] SIDE_M1 = CRD_W'(SIDE - 1);

    localparam logic [2:0] KIND_FILL = 3'd0;
    localparam logic [2:0] KIND_RECT = 3'd1;
    localparam logic [2:0] KIND_DISC = 3'd2;
    localparam logic [2:0] KIND_RING = 3'd3;
    localparam logic [2:0] KIND_READ = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_OFF,
        OP_READ,
        OP_BLOCK,
        OP_DISC,
        OP_RING
    } op_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_WALK,
        B_READ
    } back_state_t;

    typedef struct packed {
        op_t             op;
        logic [CW-1:0]   x_lo;
        logic [CW-1:0]   x_hi;
        logic [CW-1:0]   y_lo;
        logic [CW-1:0]   y_hi;
        logic [7:0]      cx;
        logic [7:0]      cy;
        logic [13:0]     outer;
        logic [13:0]     inner;
        logic [15:0]     color;
        logic [AW-1:0]   addr;
    } cmd_t;

    typedef struct packed {
        logic q_full;
        logic clearing;
    } front_stat_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [15:0]   wdata;
        logic [AW-1:0] raddr;
    } ram_req_t;

    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        logic [AW-1:0] side_a;
        side_a = AW'(SIDE);
        return AW'(y) * side_a + AW'(x);
    endfunction

endpackage
`default_nettype wire

### sv/rect_circle_raster_engine.sv
// top level of the rectangle and circle raster engine
//
// Commands go in on start/kind/pos_x/pos_y/extent_w/extent_h/paint and are
// taken at a clock edge with start high and busy low. Every command gives
// exactly one result: done is high for one cycle with read_color and
// off_screen valid; the receiver cannot stall, so it must take it then.
// A two-entry command queue lets new commands be taken while an earlier one
// is still drawing; busy rises only when the queue is full or during clear.
// Throughput is set by the pixel walker, which steps over one box pixel
// per cycle and writes those that the shape covers: a draw walks its
// clipped box (width times height for a rectangle, (2r+1) squared clipped
// to the screen for circle and ring, SIDE*SIDE = 4096 pixels for a screen
// fill). A read issues one framebuffer read; empty boxes, off screen
// reads and unused kinds are answered without a walk or a read.
// After reset the framebuffer is cleared one pixel per cycle with busy
// high, before the first command is taken.
`default_nettype none
module rect_circle_raster_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        kind,
    input  wire logic signed [7:0] pos_x,
    input  wire logic signed [7:0] pos_y,
    input  wire logic [6:0]        extent_w,
    input  wire logic [6:0]        extent_h,
    input  wire logic [15:0]       paint,
    output logic                   done,
    output logic [15:0]            read_color,
    output logic                   off_screen
);
    import rcr_pkg::*;

    cmd_t        entry, head;
    logic        push, pop, q_empty, q_full, clearing;
    front_stat_t stat;
    ram_req_t    ram_req;
    logic [15:0] ram_rdata;

    assign stat.q_full   = q_full;
    assign stat.clearing = clearing;

    rcr_front u_front (
        .start    (start),
        .kind     (kind),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .extent_w (extent_w),
        .extent_h (extent_h),
        .paint    (paint),
        .stat     (stat),
        .busy     (busy),
        .push     (push),
        .entry    (entry)
    );

    rcr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    rcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .clearing   (clearing),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .done       (done),
        .read_color (read_color),
        .off_screen (off_screen)
    );

    rcr_ram #(
        .WIDTH (16),
        .DEPTH (PIXELS)
    ) u_frame (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### sv/rcr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### sv/rcr_front.sv
// command front end: accepts, classifies and clips drawing commands
`default_nettype none
module rcr_front (
    input  wire logic               start,
    input  wire logic [2:0]         kind,
    input  wire logic signed [7:0]  pos_x,
    input  wire logic signed [7:0]  pos_y,
    input  wire logic [6:0]         extent_w,
    input  wire logic [6:0]         extent_h,
    input  wire logic [15:0]        paint,
    input  wire rcr_pkg::front_stat_t stat,
    output logic                    busy,
    output logic                    push,
    output rcr_pkg::cmd_t           entry
);
    import rcr_pkg::*;

    logic signed [CRD_W-1:0] sx, sy, sw, sh;
    logic signed [CRD_W-1:0] xl, xh, yl, yh;
    logic signed [CRD_W-1:0] cxl, cxh, cyl, cyh;
    logic                    box_empty;
    logic                    on_scr;
    logic [6:0]              r_m1;

    assign sx = CRD_W'(pos_x);
    assign sy = CRD_W'(pos_y);
    assign sw = $signed({{(CRD_W-7){1'b0}}, extent_w});
    assign sh = $signed({{(CRD_W-7){1'b0}}, extent_h});
    assign r_m1 = extent_w - 7'd1;

    assign busy = stat.q_full || stat.clearing;
    assign push = start && !busy;

    // raw box before clipping
    always_comb
    begin
        xl = '0;
        xh = SIDE_M1;
        yl = '0;
        yh = SIDE_M1;
        case (kind)
            KIND_RECT:
            begin
                xl = sx;
                xh = sx + sw - CRD_W'(1);
                yl = sy;
                yh = sy + sh - CRD_W'(1);
            end
            KIND_DISC, KIND_RING:
            begin
                xl = sx - sw;
                xh = sx + sw;
                yl = sy - sw;
                yh = sy + sw;
            end
            default:
            begin
                xl = '0;
                xh = SIDE_M1;
                yl = '0;
                yh = SIDE_M1;
            end
        endcase
    end

    assign cxl = (xl < 0) ? '0 : xl;
    assign cyl = (yl < 0) ? '0 : yl;
    assign cxh = (xh > SIDE_M1) ? SIDE_M1 : xh;
    assign cyh = (yh > SIDE_M1) ? SIDE_M1 : yh;
    assign box_empty = (cxl > cxh) || (cyl > cyh);

    assign on_scr = (sx >= 0) && (sx <= SIDE_M1) && (sy >= 0) && (sy <= SIDE_M1);

    always_comb
    begin
        entry       = '0;
        entry.x_lo  = cxl[CW-1:0];
        entry.x_hi  = cxh[CW-1:0];
        entry.y_lo  = cyl[CW-1:0];
        entry.y_hi  = cyh[CW-1:0];
        entry.cx    = pos_x;
        entry.cy    = pos_y;
        entry.outer = 14'(extent_w) * 14'(extent_w);
        // ring of radius zero must match nothing
        entry.inner = (extent_w == 7'd0) ? 14'd1 : 14'(r_m1) * 14'(r_m1);
        entry.color = paint;
        entry.addr  = pix_addr(sx[CW-1:0], sy[CW-1:0]);
        case (kind)
            KIND_FILL, KIND_RECT: entry.op = box_empty ? OP_NOP : OP_BLOCK;
            KIND_DISC:            entry.op = box_empty ? OP_NOP : OP_DISC;
            KIND_RING:            entry.op = box_empty ? OP_NOP : OP_RING;
            KIND_READ:            entry.op = on_scr ? OP_READ : OP_OFF;
            default:              entry.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

### sv/rcr_queue.sv
// short command queue between front end and pixel walker
`default_nettype none
`include "rect_circle_raster_engine_assert.svh"
module rcr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rcr_pkg::cmd_t entry,
    input  wire logic          pop,
    output rcr_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);
    import rcr_pkg::*;

    cmd_t          mem_reg [QDEPTH];
    logic [QW-1:0] wp_reg, wp_next;
    logic [QW-1:0] rp_reg, rp_next;
    logic [QW:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QW+1)'(QDEPTH));
    assign head  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == QW'(QDEPTH - 1)) ? '0 : wp_reg + QW'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == QW'(QDEPTH - 1)) ? '0 : rp_reg + QW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (QW+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (QW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= entry;
        end
    end

    `RCR_NEVER(a_q_overflow, push && full && !pop, "queue transfer into a full queue")
    `RCR_NEVER(a_q_underflow, pop && empty, "pop from an empty queue")
    `RCR_ASSERT(a_q_count, push && !pop && !full |=> !empty, "queue lost a pushed entry")

endmodule
`default_nettype wire

### sv/rcr_back.sv
// back end: clears the frame, walks command boxes and answers reads
`default_nettype none
`include "rect_circle_raster_engine_assert.svh"
module rcr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rcr_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               clearing,
    output rcr_pkg::ram_req_t  ram_req,
    input  wire logic [15:0]   ram_rdata,
    output logic               done,
    output logic [15:0]        read_color,
    output logic               off_screen
);
    import rcr_pkg::*;

    back_state_t   state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    logic [15:0]   read_color_reg, read_color_next;
    logic          off_screen_reg, off_screen_next;

    logic                    walk_last;
    logic                    clr_last;
    logic signed [CRD_W-1:0] dx, dy;
    logic [6:0]              ax, ay;
    logic [13:0]             dx2, dy2;
    logic [14:0]             rad_sq;
    logic                    hit;

    assign walk_last = (x_reg == cur_reg.x_hi) && (y_reg == cur_reg.y_hi);
    assign clr_last  = (clr_reg == AW'(PIXELS - 1));

    // offset of the current pixel from the centre; the box keeps it within the radius
    assign dx     = $signed({{(CRD_W-CW){1'b0}}, x_reg}) - CRD_W'($signed(cur_reg.cx));
    assign dy     = $signed({{(CRD_W-CW){1'b0}}, y_reg}) - CRD_W'($signed(cur_reg.cy));
    assign ax     = (dx < 0) ? 7'(-dx) : dx[6:0];
    assign ay     = (dy < 0) ? 7'(-dy) : dy[6:0];
    assign dx2    = 14'(ax) * 14'(ax);
    assign dy2    = 14'(ay) * 14'(ay);
    assign rad_sq = {1'b0, dx2} + {1'b0, dy2};

    always_comb
    begin
        case (cur_reg.op)
            OP_BLOCK: hit = 1'b1;
            OP_DISC:  hit = (rad_sq <= {1'b0, cur_reg.outer});
            OP_RING:  hit = (rad_sq <= {1'b0, cur_reg.outer}) &&
                            (rad_sq >= {1'b0, cur_reg.inner});
            default:  hit = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.op)
                        OP_BLOCK, OP_DISC, OP_RING: state_next = B_WALK;
                        OP_READ:                    state_next = B_READ;
                        default:                    state_next = B_IDLE;
                    endcase
                end
            end
            B_WALK:
            begin
                if (walk_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_READ:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop             = 1'b0;
        clearing        = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = pix_addr(x_reg, y_reg);
        ram_req.wdata   = cur_reg.color;
        ram_req.raddr   = head.addr;
        cur_next        = cur_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        read_color_next = read_color_reg;
        off_screen_next = off_screen_reg;
        case (state_reg)
            B_CLEAR:
            begin
                clearing      = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + AW'(1);
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    x_next   = head.x_lo;
                    y_next   = head.y_lo;
                    if (head.op == OP_NOP || head.op == OP_OFF)
                    begin
                        done_next       = 1'b1;
                        read_color_next = '0;
                        off_screen_next = (head.op == OP_OFF);
                    end
                end
            end
            B_WALK:
            begin
                ram_req.we = hit;
                if (x_reg == cur_reg.x_hi)
                begin
                    x_next = cur_reg.x_lo;
                    y_next = y_reg + CW'(1);
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
                if (walk_last)
                begin
                    done_next       = 1'b1;
                    read_color_next = '0;
                    off_screen_next = 1'b0;
                end
            end
            B_READ:
            begin
                done_next       = 1'b1;
                read_color_next = ram_rdata;
                off_screen_next = 1'b0;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        read_color_reg <= read_color_next;
        off_screen_reg <= off_screen_next;
    end

    assign done       = done_reg;
    assign read_color = read_color_reg;
    assign off_screen = off_screen_reg;

    `RCR_NEVER(a_no_pop_while_busy, pop && state_reg != B_IDLE, "queue popped outside idle")
    `RCR_ASSERT(a_read_answers, state_reg == B_READ |=> done_reg && !off_screen_reg, "read gave no result")
    `RCR_ASSERT(a_off_is_blank, done_reg && off_screen_reg |-> read_color_reg == '0, "off screen read carried a color")

endmodule
`default_nettype wire

### tb/rect_circle_raster_engine_test.sv
// self-checking testbench for the rectangle and circle raster engine
module rect_circle_raster_engine_test;
    import rcr_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_CMDS = 115;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    logic [2:0]        kind     = '0;
    logic signed [7:0] pos_x    = '0;
    logic signed [7:0] pos_y    = '0;
    logic [6:0]        extent_w = '0;
    logic [6:0]        extent_h = '0;
    logic [15:0]       paint    = '0;
    logic              done;
    logic [15:0]       read_color;
    logic              off_screen;

    bit gaps_on = 1'b1;
    int idle_cycles = 0;

    typedef struct {
        logic [15:0] color;
        logic        off;
    } pixel_answer_t;

    class raster_scoreboard;
        logic [15:0]   frame [PIXELS];
        pixel_answer_t answers [$];
        int            errors;

        function new();
            foreach (frame[i])
                frame[i] = '0;
            errors = 0;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function void put_pixel(int x, int y, logic [15:0] c);
            if (x >= 0 && y >= 0 && x < SIDE && y < SIDE)
                frame[y * SIDE + x] = c;
        endfunction

        function void plot_round(int cx, int cy, int r, logic [15:0] c, bit solid);
            int outer;
            int inner;
            int d;
            outer = r * r;
            inner = (r - 1) * (r - 1);
            for (int dy = -r; dy <= r; dy++)
                for (int dx = -r; dx <= r; dx++)
                begin
                    d = dx * dx + dy * dy;
                    if (d <= outer && (solid || d >= inner))
                        put_pixel(cx + dx, cy + dy, c);
                end
        endfunction

        // applies one accepted command to the frame copy and queues its answer
        function void note_command(logic [2:0] k, logic signed [7:0] x, logic signed [7:0] y,
                                   logic [6:0] w, logic [6:0] h, logic [15:0] c);
            pixel_answer_t a;
            int xs;
            int ys;
            int ws;
            int hs;
            xs = x;
            ys = y;
            ws = w;
            hs = h;
            a.color = '0;
            a.off = 1'b0;
            case (k)
                KIND_FILL:
                    foreach (frame[i])
                        frame[i] = c;
                KIND_RECT:
                    for (int j = 0; j < hs; j++)
                        for (int i = 0; i < ws; i++)
                            put_pixel(xs + i, ys + j, c);
                KIND_DISC:
                    plot_round(xs, ys, ws, c, 1'b1);
                KIND_RING:
                    plot_round(xs, ys, ws, c, 1'b0);
                KIND_READ:
                    if (xs >= 0 && ys >= 0 && xs < SIDE && ys < SIDE)
                        a.color = frame[ys * SIDE + xs];
                    else
                        a.off = 1'b1;
                default:
                    ;
            endcase
            answers.push_back(a);
        endfunction

        function void check_result(logic [15:0] color, logic off);
            pixel_answer_t a;
            if (answers.size() == 0)
            begin
                $error("result with no command outstanding: read_color %h off_screen %b",
                       color, off);
                errors++;
                return;
            end
            a = answers.pop_front();
            if (color !== a.color)
            begin
                $error("read_color: expected %h, got %h", a.color, color);
                errors++;
            end
            if (off !== a.off)
            begin
                $error("off_screen: expected %b, got %b", a.off, off);
                errors++;
            end
        endfunction
    endclass

    raster_scoreboard frame_check = new();

    rect_circle_raster_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .extent_w   (extent_w),
        .extent_h   (extent_h),
        .paint      (paint),
        .done       (done),
        .read_color (read_color),
        .off_screen (off_screen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            frame_check.check_result(read_color, off_screen);
    end

    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic issue_command(input logic [2:0] k, input logic signed [7:0] x,
                                 input logic signed [7:0] y, input logic [6:0] w,
                                 input logic [6:0] h, input logic [15:0] c);
        if (gaps_on)
            while ($urandom_range(99) < 25)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start    <= 1'b1;
        kind     <= k;
        pos_x    <= x;
        pos_y    <= y;
        extent_w <= w;
        extent_h <= h;
        paint    <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        frame_check.note_command(k, x, y, w, h, c);
    endtask

    task automatic run_directed();
        // untouched screen, then edges of the screen and off screen reads
        issue_command(KIND_READ, 0, 0, 0, 0, 16'h0000);
        issue_command(KIND_READ, 63, 63, 0, 0, 16'h0000);
        issue_command(KIND_READ, 64, 0, 0, 0, 16'h0000);
        issue_command(KIND_READ, -1, 5, 0, 0, 16'h0000);
        issue_command(KIND_READ, -128, 127, 127, 127, 16'hFFFF);
        issue_command(KIND_FILL, 0, 0, 0, 0, 16'hFFFF);
        issue_command(KIND_READ, 63, 0, 0, 0, 16'h0000);
        // empty rectangles, then ones clipped on each side
        issue_command(KIND_RECT, 10, 10, 0, 5, 16'h1111);
        issue_command(KIND_RECT, 12, 12, 5, 0, 16'h2222);
        issue_command(KIND_RECT, -3, -3, 10, 10, 16'hA5A5);
        issue_command(KIND_RECT, 60, 60, 127, 127, 16'h5A5A);
        issue_command(KIND_READ, 0, 0, 0, 0, 16'h0000);
        issue_command(KIND_READ, 63, 63, 0, 0, 16'h0000);
        // zero radius: disc hits only its centre, ring hits nothing
        issue_command(KIND_DISC, 20, 20, 0, 0, 16'h0F0F);
        issue_command(KIND_RING, 40, 40, 0, 0, 16'hF0F0);
        issue_command(KIND_READ, 20, 20, 0, 0, 16'h0000);
        issue_command(KIND_READ, 40, 40, 0, 0, 16'h0000);
        issue_command(KIND_DISC, 32, 32, 127, 127, 16'h0000);
        issue_command(KIND_RING, 30, 30, 6, 0, 16'h8001);
        issue_command(KIND_READ, 36, 30, 0, 0, 16'h0000);
        issue_command(KIND_READ, 30, 30, 0, 0, 16'h0000);
        issue_command(KIND_DISC, -10, -10, 15, 0, 16'h7E7E);
        issue_command(3'd5, 127, -128, 127, 127, 16'hFFFF);
        issue_command(3'd6, 5, 5, 3, 3, 16'h1234);
        issue_command(3'd7, 0, 0, 0, 0, 16'h0000);
    endtask

    function automatic logic signed [7:0] pick_coord();
        if ($urandom_range(99) < 85)
            return 8'(int'($urandom_range(0, 79)) - 8);
        return 8'($urandom);
    endfunction

    function automatic logic [6:0] pick_extent();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 7'($urandom_range(0, 12));
        if (roll < 95)
            return 7'($urandom_range(0, 40));
        return 7'($urandom);
    endfunction

    task automatic run_random();
        logic [2:0]        k;
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [6:0]        w;
        logic [6:0]        h;
        logic [15:0]       c;
        int                roll;
        int                spread;
        int                last_x;
        int                last_y;
        int                last_r;
        last_x = 32;
        last_y = 32;
        last_r = 4;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            gaps_on = !(n >= 40 && n < 75);
            if (n == 100)
            begin
                // hold off until the engine has answered everything
                start <= 1'b0;
                @(posedge clk);
                while (frame_check.pending() != 0)
                    @(posedge clk);
            end
            roll = $urandom_range(99);
            c = 16'($urandom);
            x = pick_coord();
            y = pick_coord();
            w = pick_extent();
            h = pick_extent();
            if (roll < 3)
                k = KIND_FILL;
            else if (roll < 30)
                k = KIND_RECT;
            else if (roll < 45)
                k = KIND_DISC;
            else if (roll < 58)
                k = KIND_RING;
            else if (roll < 95)
            begin
                k = KIND_READ;
                // mostly probe around the last drawn shape
                if ($urandom_range(99) < 65)
                begin
                    spread = last_r + 1;
                    x = 8'(last_x - spread + int'($urandom_range(0, 2 * spread)));
                    y = 8'(last_y - spread + int'($urandom_range(0, 2 * spread)));
                end
            end
            else
                k = 3'($urandom_range(5, 7));
            if (k == KIND_RECT || k == KIND_DISC || k == KIND_RING)
            begin
                last_x = x;
                last_y = y;
                last_r = w;
            end
            issue_command(k, x, y, w, h, c);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        start <= 1'b0;
        while (frame_check.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (frame_check.errors == 0 && frame_check.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/rcr_pkg.sv
sv/rcr_ram.sv
sv/rcr_front.sv
sv/rcr_queue.sv
sv/rcr_back.sv
sv/rect_circle_raster_engine.sv
tb/rect_circle_raster_engine_test.sv
